@@ rtl/rha_pkg.sv @@
// rha_pkg: shared constants, command codes and controller/datapath types
// for the range histogram accumulator. No dependencies.
package rha_pkg;

    localparam int MAX_BINS       = 256;
    localparam int BIN_BITS       = $clog2(MAX_BINS);
    localparam int BINS_CFG_BITS  = BIN_BITS + 1;
    localparam int VALUE_BITS     = 32;
    localparam int COUNT_BITS     = 32;
    localparam int SCALE_BITS     = 32;
    localparam int CMD_BITS       = 2;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_MIN   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_MAX   = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BINS_IN_USE = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIN_SCALE   = 8'd3;

    localparam logic [VALUE_BITS-1:0]    RANGE_MIN_RST   = 32'sd0;
    localparam logic [VALUE_BITS-1:0]    RANGE_MAX_RST   = 32'sd16777216;
    localparam logic [BINS_CFG_BITS-1:0] BINS_IN_USE_RST = BINS_CFG_BITS'(MAX_BINS);
    localparam logic [SCALE_BITS-1:0]    BIN_SCALE_RST   = 32'd65536;

    typedef struct packed {
        logic load;
        logic mul;
        logic rd;
        logic upd;
    } rha_ctrl_t;

endpackage

@@ rtl/rha_ctrl.sv @@
// rha_ctrl: command sequencer for the range histogram accumulator.
// Depends on rha_pkg for command codes and the control struct.
module rha_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rha_pkg::CMD_BITS-1:0]  cmd,
    output logic                          busy,
    output rha_pkg::rha_ctrl_t            ctrl
);
    import rha_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADDR = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    if (cmd == CMD_SAMPLE)
                        state_next = S_MUL;
                    else if (cmd == CMD_READ)
                        state_next = S_ADDR;
                    else
                        state_next = S_UPD;
                end
            end
            S_MUL:
            begin
                ctrl.mul   = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                ctrl.rd    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                ctrl.upd   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/rha_datapath.sv @@
// rha_datapath: config registers, range test, bin multiply, bin count memory
// with valid bits, totals and result registers. Depends on rha_pkg.
module rha_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rha_pkg::rha_ctrl_t                  ctrl,
    input  logic [rha_pkg::CMD_BITS-1:0]        cmd,
    input  logic [rha_pkg::VALUE_BITS-1:0]      value,
    input  logic [rha_pkg::BIN_BITS-1:0]        read_bin,
    input  logic                                cfg_we,
    input  logic [rha_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rha_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                result_valid,
    output logic                                accepted,
    output logic [rha_pkg::BIN_BITS-1:0]        bin_used,
    output logic [rha_pkg::COUNT_BITS-1:0]      bin_total,
    output logic [rha_pkg::COUNT_BITS-1:0]      samples_total,
    output logic [rha_pkg::COUNT_BITS-1:0]      rejects_total
);
    import rha_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [VALUE_BITS-1:0]    range_min_reg;
    logic [VALUE_BITS-1:0]    range_max_reg;
    logic [BINS_CFG_BITS-1:0] bins_reg;
    logic [SCALE_BITS-1:0]    scale_reg;

    logic [CMD_BITS-1:0]      cmd_reg;
    logic [VALUE_BITS-1:0]    value_reg;
    logic [BIN_BITS-1:0]      read_bin_reg;

    logic                     in_range_reg;
    logic [SCALE_BITS-1:0]    prod_reg;
    logic [BIN_BITS-1:0]      addr_reg;
    logic [COUNT_BITS-1:0]    rd_data_reg;
    logic                     rd_valid_reg;

    logic [COUNT_BITS-1:0]    bin_mem [MAX_BINS];
    logic [MAX_BINS-1:0]      bin_valid_reg;
    logic [COUNT_BITS-1:0]    sample_cnt_reg;
    logic [COUNT_BITS-1:0]    reject_cnt_reg;

    logic                     result_valid_reg;
    logic                     accepted_reg;
    logic [BIN_BITS-1:0]      bin_used_reg;
    logic [COUNT_BITS-1:0]    bin_total_reg;

    logic                     cfg_hit;
    logic                     clear_all;
    logic                     in_range;
    logic [VALUE_BITS-1:0]    diff;
    logic [2*VALUE_BITS-1:0]  prod;
    logic [BINS_CFG_BITS-1:0] eff_bins;
    logic [BINS_CFG_BITS-1:0] last_bin;
    logic [BIN_BITS-1:0]      addr;
    logic [COUNT_BITS-1:0]    cur_count;
    logic [COUNT_BITS-1:0]    new_count;
    logic                     do_sample;
    logic                     do_reject;

    assign cfg_hit = cfg_we && (cfg_index == CFG_RANGE_MIN || cfg_index == CFG_RANGE_MAX
                     || cfg_index == CFG_BINS_IN_USE || cfg_index == CFG_BIN_SCALE);
    assign clear_all = cfg_hit || (ctrl.upd && cmd_reg == CMD_CLEAR);

    assign in_range = ($signed(range_min_reg) < $signed(value_reg))
                      && ($signed(value_reg) < $signed(range_max_reg));
    assign diff = value_reg - range_min_reg;
    assign prod = {{VALUE_BITS{1'b0}}, diff} * {{(2*VALUE_BITS-SCALE_BITS){1'b0}}, scale_reg};

    always_comb
    begin
        if (bins_reg == '0)
            eff_bins = BINS_CFG_BITS'(1);
        else if (bins_reg > BINS_CFG_BITS'(MAX_BINS))
            eff_bins = BINS_CFG_BITS'(MAX_BINS);
        else
            eff_bins = bins_reg;
        last_bin = eff_bins - BINS_CFG_BITS'(1);
    end

    always_comb
    begin
        if (cmd_reg != CMD_SAMPLE)
            addr = read_bin_reg;
        else if (prod_reg > SCALE_BITS'(last_bin))
            addr = last_bin[BIN_BITS-1:0];
        else
            addr = prod_reg[BIN_BITS-1:0];
    end

    assign cur_count = rd_valid_reg ? rd_data_reg : '0;
    assign new_count = (cur_count == COUNT_MAX) ? COUNT_MAX : cur_count + 1'b1;
    assign do_sample = ctrl.upd && cmd_reg == CMD_SAMPLE && in_range_reg;
    assign do_reject = ctrl.upd && cmd_reg == CMD_SAMPLE && !in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= RANGE_MIN_RST;
            range_max_reg <= RANGE_MAX_RST;
            bins_reg      <= BINS_IN_USE_RST;
            scale_reg     <= BIN_SCALE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RANGE_MIN)
                range_min_reg <= cfg_data[VALUE_BITS-1:0];
            if (cfg_index == CFG_RANGE_MAX)
                range_max_reg <= cfg_data[VALUE_BITS-1:0];
            if (cfg_index == CFG_BINS_IN_USE)
                bins_reg <= cfg_data[BINS_CFG_BITS-1:0];
            if (cfg_index == CFG_BIN_SCALE)
                scale_reg <= cfg_data[SCALE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg      <= cmd;
            value_reg    <= value;
            read_bin_reg <= read_bin;
        end
        if (ctrl.mul)
        begin
            in_range_reg <= in_range;
            prod_reg     <= prod[2*VALUE_BITS-1:VALUE_BITS];
        end
        if (ctrl.rd)
        begin
            addr_reg     <= addr;
            rd_data_reg  <= bin_mem[addr];
            rd_valid_reg <= bin_valid_reg[addr];
        end
        if (ctrl.upd)
        begin
            accepted_reg <= do_sample;
            if (do_sample || cmd_reg == CMD_READ)
                bin_used_reg <= addr_reg;
            else
                bin_used_reg <= '0;
            if (do_sample)
                bin_total_reg <= new_count;
            else if (cmd_reg == CMD_READ)
                bin_total_reg <= cur_count;
            else
                bin_total_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_sample)
            bin_mem[addr_reg] <= new_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg    <= '0;
            sample_cnt_reg   <= '0;
            reject_cnt_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctrl.upd;
            if (clear_all)
            begin
                bin_valid_reg  <= '0;
                sample_cnt_reg <= '0;
                reject_cnt_reg <= '0;
            end
            else
            begin
                if (do_sample)
                begin
                    bin_valid_reg[addr_reg] <= 1'b1;
                    if (sample_cnt_reg != COUNT_MAX)
                        sample_cnt_reg <= sample_cnt_reg + 1'b1;
                end
                if (do_reject && reject_cnt_reg != COUNT_MAX)
                    reject_cnt_reg <= reject_cnt_reg + 1'b1;
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign accepted      = accepted_reg;
    assign bin_used      = bin_used_reg;
    assign bin_total     = bin_total_reg;
    assign samples_total = sample_cnt_reg;
    assign rejects_total = reject_cnt_reg;

endmodule

@@ rtl/range_histogram_accumulator.sv @@
// range_histogram_accumulator: top level joining the sequencer and datapath.
// Depends on rha_pkg, rha_ctrl and rha_datapath.
//
// Usage: pulse start with cmd/value/read_bin while busy is low. cmd 0 bins a
// signed Q16.16 sample, 1 reads one bin, 2 clears all bins and totals.
// Each item yields one result, shown for one cycle with result_valid high.
// From the accepting edge (which captures the item) to result_valid, a sample
// passes the 32x32 bin multiply, bin memory read and update; a read passes
// the read and update; clear and undefined commands go straight to update.
// busy stays high until the result is registered, so a new sample is taken
// only after the last is through (read-modify-write of the single-port bin
// memory after the multiplier). Clear drops per-bin valid bits at once.
// Config: cfg_valid/cfg_ready write register cfg_index with cfg_data; any
// write to a defined register also clears the histogram. cfg_ready is low
// while busy.
// Reset restores default config and an empty histogram; no warm-up pass.
// The receiver cannot stall; results must be taken on the strobe.
module range_histogram_accumulator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rha_pkg::CMD_BITS-1:0]        cmd,
    input  logic [rha_pkg::VALUE_BITS-1:0]      value,
    input  logic [rha_pkg::BIN_BITS-1:0]        read_bin,
    output logic                                result_valid,
    output logic                                accepted,
    output logic [rha_pkg::BIN_BITS-1:0]        bin_used,
    output logic [rha_pkg::COUNT_BITS-1:0]      bin_total,
    output logic [rha_pkg::COUNT_BITS-1:0]      samples_total,
    output logic [rha_pkg::COUNT_BITS-1:0]      rejects_total,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rha_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rha_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import rha_pkg::*;

    rha_ctrl_t ctrl;
    logic      start_ok;

    assign start_ok  = start && !busy;
    assign cfg_ready = !busy;

    rha_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    rha_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cmd           (cmd),
        .value         (value),
        .read_bin      (read_bin),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .accepted      (accepted),
        .bin_used      (bin_used),
        .bin_total     (bin_total),
        .samples_total (samples_total),
        .rejects_total (rejects_total)
    );

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_ok |=> busy)
        else $error("accepted item did not raise busy");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while still busy");

    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("two results in consecutive cycles");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && accepted) |-> (bin_total != '0 && samples_total != '0))
        else $error("accepted sample left a zero count");
`endif

endmodule
